// ===== src/ebi_pkg.sv =====
package ebi_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_BOX_X_LOW  = 2'd0;
    localparam cfg_index_t REG_BOX_Y_LOW  = 2'd1;
    localparam cfg_index_t REG_BOX_X_HIGH = 2'd2;
    localparam cfg_index_t REG_BOX_Y_HIGH = 2'd3;

    // Stage load enables shared by the side lanes.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } stage_ctrl_t;

    localparam int OUT_DATA_WIDTH = 8;

endpackage

// ===== src/ebi_side.sv =====
// One box side tested against the segment, in three register stages:
// differences and range checks, cross products, product compare.
// Coordinates arrive already swapped for the vertical sides.
module ebi_side #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  ebi_pkg::stage_ctrl_t          ctrl,
    input  logic signed [COORD_WIDTH-1:0] x0,
    input  logic signed [COORD_WIDTH-1:0] y0,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] ua,
    input  logic signed [COORD_WIDTH-1:0] ub,
    input  logic signed [COORD_WIDTH-1:0] lev,
    output logic                          meets
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;

    // Stage 1
    logic signed [DW-1:0] da_reg, db_reg, dl_reg, dx_reg, dy_reg;
    logic signed [DW-1:0] da_next, db_next, dl_next, dx_next, dy_next;
    logic                 skip1_reg, flat1_reg, overlap1_reg;
    logic                 skip1_next, flat1_next, overlap1_next;
    logic signed [COORD_WIDTH-1:0] seg_lo, seg_hi, side_lo, side_hi;

    // Stage 2
    logic signed [PW-1:0] pa_reg, pb_reg, pl_reg;
    logic                 skip2_reg, flat2_reg, overlap2_reg;

    // Stage 3
    logic meets_reg, meets_next;
    logic a_above, a_below, b_above, b_below;

    always_comb
    begin
        skip1_next = ((y0 > lev) && (y1 > lev)) || ((y0 < lev) && (y1 < lev));
        flat1_next = (y1 == y0);
        seg_lo     = (x0 < x1) ? x0 : x1;
        seg_hi     = (x0 > x1) ? x0 : x1;
        side_lo    = (ua < ub) ? ua : ub;
        side_hi    = (ua > ub) ? ua : ub;
        overlap1_next = ((seg_lo > side_lo) ? seg_lo : side_lo)
                        <= ((seg_hi < side_hi) ? seg_hi : side_hi);
        da_next = DW'(ua)  - DW'(x0);
        db_next = DW'(ub)  - DW'(x0);
        dl_next = DW'(lev) - DW'(y0);
        dx_next = DW'(x1)  - DW'(x0);
        dy_next = DW'(y1)  - DW'(y0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            da_reg       <= da_next;
            db_reg       <= db_next;
            dl_reg       <= dl_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            skip1_reg    <= skip1_next;
            flat1_reg    <= flat1_next;
            overlap1_reg <= overlap1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            pa_reg       <= PW'(da_reg) * PW'(dy_reg);
            pb_reg       <= PW'(db_reg) * PW'(dy_reg);
            pl_reg       <= PW'(dl_reg) * PW'(dx_reg);
            skip2_reg    <= skip1_reg;
            flat2_reg    <= flat1_reg;
            overlap2_reg <= overlap1_reg;
        end
    end

    // Both side ends strictly on one side of the segment's line means no crossing.
    always_comb
    begin
        a_above = pa_reg > pl_reg;
        a_below = pa_reg < pl_reg;
        b_above = pb_reg > pl_reg;
        b_below = pb_reg < pl_reg;
        if (skip2_reg)
        begin
            meets_next = 1'b0;
        end
        else if (flat2_reg)
        begin
            meets_next = overlap2_reg;
        end
        else
        begin
            meets_next = !((a_above && b_above) || (a_below && b_below));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load3)
        begin
            meets_reg <= meets_next;
        end
    end

    assign meets = meets_reg;

endmodule

// ===== src/edge_box_intersection_core.sv =====
// Segment against box touch test, fully pipelined.
// Path from input to output port: stage 1, stage 2 and stage 3 registers, then the output register.
// Throughput: one segment per cycle; the four side lanes and their
// multipliers are pipelined, so stalls only occur on output back-pressure.
// Reset: rst_n clears all valid bits and sets the box to the full range.
module edge_box_intersection_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_x, start_y, finish_x, finish_y from bit 0 up, zero padded to bytes.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // touches_box in bit 0, upper bits zero.
    output logic [ebi_pkg::OUT_DATA_WIDTH-1:0]     m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  ebi_pkg::cfg_index_t                    cfg_index,
    input  logic [COORD_WIDTH-1:0]                 cfg_data
);

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};

    logic signed [W-1:0] box_x_low_reg, box_y_low_reg, box_x_high_reg, box_y_high_reg;
    logic signed [W-1:0] start_x, start_y, finish_x, finish_y;

    logic valid1_reg, valid2_reg, valid3_reg, out_valid_reg;
    logic ready1, ready2, ready3, ready_out;

    logic reject1_reg, reject2_reg, reject3_reg;
    logic inside1_reg, inside2_reg, inside3_reg;
    logic reject_next, inside_next;
    logic touches_reg, touches_next;

    logic [3:0] side_meets;
    ebi_pkg::stage_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_low_reg  <= COORD_MIN;
            box_y_low_reg  <= COORD_MIN;
            box_x_high_reg <= COORD_MAX;
            box_y_high_reg <= COORD_MAX;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ebi_pkg::REG_BOX_X_LOW:  box_x_low_reg  <= cfg_data;
                ebi_pkg::REG_BOX_Y_LOW:  box_y_low_reg  <= cfg_data;
                ebi_pkg::REG_BOX_X_HIGH: box_x_high_reg <= cfg_data;
                ebi_pkg::REG_BOX_Y_HIGH: box_y_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign start_x  = s_axis_tdata[W-1:0];
    assign start_y  = s_axis_tdata[2*W-1:W];
    assign finish_x = s_axis_tdata[3*W-1:2*W];
    assign finish_y = s_axis_tdata[4*W-1:3*W];

    // A stage takes new data when it is empty or the stage after it moves on.
    assign ready_out     = !out_valid_reg || m_axis_tready;
    assign ready3        = !valid3_reg || ready_out;
    assign ready2        = !valid2_reg || ready3;
    assign ready1        = !valid1_reg || ready2;
    assign s_axis_tready = ready1;

    assign ctrl.load1 = ready1;
    assign ctrl.load2 = ready2;
    assign ctrl.load3 = ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                valid1_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (ready3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= valid3_reg;
            end
        end
    end

    always_comb
    begin
        reject_next = ((start_x > box_x_high_reg) && (finish_x > box_x_high_reg))
                   || ((start_x < box_x_low_reg)  && (finish_x < box_x_low_reg))
                   || ((start_y > box_y_high_reg) && (finish_y > box_y_high_reg))
                   || ((start_y < box_y_low_reg)  && (finish_y < box_y_low_reg));
        inside_next = ((box_x_low_reg <= start_x) && (start_x <= box_x_high_reg)
                       && (box_y_low_reg <= start_y) && (start_y <= box_y_high_reg))
                   || ((box_x_low_reg <= finish_x) && (finish_x <= box_x_high_reg)
                       && (box_y_low_reg <= finish_y) && (finish_y <= box_y_high_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            reject1_reg <= reject_next;
            inside1_reg <= inside_next;
        end
        if (ready2)
        begin
            reject2_reg <= reject1_reg;
            inside2_reg <= inside1_reg;
        end
        if (ready3)
        begin
            reject3_reg <= reject2_reg;
            inside3_reg <= inside2_reg;
        end
    end

    ebi_side #(.COORD_WIDTH(W)) u_side_bottom (
        .clk  (clk),
        .ctrl (ctrl),
        .x0   (start_x),
        .y0   (start_y),
        .x1   (finish_x),
        .y1   (finish_y),
        .ua   (box_x_low_reg),
        .ub   (box_x_high_reg),
        .lev  (box_y_low_reg),
        .meets(side_meets[0])
    );

    ebi_side #(.COORD_WIDTH(W)) u_side_top (
        .clk  (clk),
        .ctrl (ctrl),
        .x0   (start_x),
        .y0   (start_y),
        .x1   (finish_x),
        .y1   (finish_y),
        .ua   (box_x_low_reg),
        .ub   (box_x_high_reg),
        .lev  (box_y_high_reg),
        .meets(side_meets[1])
    );

    // Vertical sides use the same lane with x and y exchanged.
    ebi_side #(.COORD_WIDTH(W)) u_side_left (
        .clk  (clk),
        .ctrl (ctrl),
        .x0   (start_y),
        .y0   (start_x),
        .x1   (finish_y),
        .y1   (finish_x),
        .ua   (box_y_low_reg),
        .ub   (box_y_high_reg),
        .lev  (box_x_low_reg),
        .meets(side_meets[2])
    );

    ebi_side #(.COORD_WIDTH(W)) u_side_right (
        .clk  (clk),
        .ctrl (ctrl),
        .x0   (start_y),
        .y0   (start_x),
        .x1   (finish_y),
        .y1   (finish_x),
        .ua   (box_y_low_reg),
        .ub   (box_y_high_reg),
        .lev  (box_x_high_reg),
        .meets(side_meets[3])
    );

    assign touches_next = !reject3_reg && (inside3_reg || (|side_meets));

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            touches_reg <= touches_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ebi_pkg::OUT_DATA_WIDTH-1){1'b0}}, touches_reg};

endmodule

// ===== test/tb_edge_box_intersection_core.sv =====
`timescale 1ns / 100ps

module tb_edge_box_intersection_core;

    localparam int CW = 16;
    localparam int DW = ((4*CW+7)/8)*8;
    localparam int COORD_MIN = -32768;
    localparam int COORD_MAX = 32767;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 110;

    class touch_scoreboard;
        longint x_lo;
        longint y_lo;
        longint x_hi;
        longint y_hi;
        bit touch_q[$];
        int errors;

        function new();
            x_lo = longint'(COORD_MIN);
            y_lo = longint'(COORD_MIN);
            x_hi = longint'(COORD_MAX);
            y_hi = longint'(COORD_MAX);
            errors = 0;
        endfunction

        function void write_box_reg(ebi_pkg::cfg_index_t idx, logic [CW-1:0] value);
            longint v;
            v = longint'($signed(value));
            case (idx)
                ebi_pkg::REG_BOX_X_LOW:  x_lo = v;
                ebi_pkg::REG_BOX_Y_LOW:  y_lo = v;
                ebi_pkg::REG_BOX_X_HIGH: x_hi = v;
                ebi_pkg::REG_BOX_Y_HIGH: y_hi = v;
                default: ;
            endcase
        endfunction

        // Sign of a*b - c*d; 16-bit coordinates keep this well inside 64 bits.
        function int cross_sign(longint a, longint b, longint c, longint d);
            longint p;
            p = a * b - c * d;
            return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
        endfunction

        // Segment against the side at v = lev spanning u in [ua, ub].
        function bit hits_side(longint u0, longint v0, longint u1, longint v1,
                               longint ua, longint ub, longint lev);
            longint du;
            longint dv;
            longint seg_lo;
            longint seg_hi;
            longint side_lo;
            longint side_hi;
            int sign_a;
            int sign_b;
            if (v0 > lev && v1 > lev)
                return 1'b0;
            if (v0 < lev && v1 < lev)
                return 1'b0;
            dv = v1 - v0;
            du = u1 - u0;
            if (dv == 0)
            begin
                // The segment runs along the side: plain interval overlap.
                seg_lo  = (u0 < u1) ? u0 : u1;
                seg_hi  = (u0 > u1) ? u0 : u1;
                side_lo = (ua < ub) ? ua : ub;
                side_hi = (ua > ub) ? ua : ub;
                return ((seg_lo > side_lo) ? seg_lo : side_lo) <=
                       ((seg_hi < side_hi) ? seg_hi : side_hi);
            end
            sign_a = cross_sign(ua - u0, dv, lev - v0, du);
            sign_b = cross_sign(ub - u0, dv, lev - v0, du);
            if (sign_a > 0 && sign_b > 0)
                return 1'b0;
            if (sign_a < 0 && sign_b < 0)
                return 1'b0;
            return 1'b1;
        endfunction

        function bit predict_touch(logic [DW-1:0] seg);
            longint sx;
            longint sy;
            longint fx;
            longint fy;
            sx = longint'($signed(seg[CW-1:0]));
            sy = longint'($signed(seg[2*CW-1:CW]));
            fx = longint'($signed(seg[3*CW-1:2*CW]));
            fy = longint'($signed(seg[4*CW-1:3*CW]));
            if (sx > x_hi && fx > x_hi) return 1'b0;
            if (sx < x_lo && fx < x_lo) return 1'b0;
            if (sy > y_hi && fy > y_hi) return 1'b0;
            if (sy < y_lo && fy < y_lo) return 1'b0;
            if (x_lo <= sx && sx <= x_hi && y_lo <= sy && sy <= y_hi) return 1'b1;
            if (x_lo <= fx && fx <= x_hi && y_lo <= fy && fy <= y_hi) return 1'b1;
            if (hits_side(sx, sy, fx, fy, x_lo, x_hi, y_lo)) return 1'b1;
            if (hits_side(sx, sy, fx, fy, x_lo, x_hi, y_hi)) return 1'b1;
            if (hits_side(sy, sx, fy, fx, y_lo, y_hi, x_lo)) return 1'b1;
            if (hits_side(sy, sx, fy, fx, y_lo, y_hi, x_hi)) return 1'b1;
            return 1'b0;
        endfunction

        function void note_segment(logic [DW-1:0] seg);
            touch_q.push_back(predict_touch(seg));
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [ebi_pkg::OUT_DATA_WIDTH-1:0] data);
            bit want;
            if (touch_q.size() == 0)
            begin
                report($sformatf("touches_box %b with no segment outstanding", data[0]));
                return;
            end
            want = touch_q.pop_front();
            if (data[0] !== want)
                report($sformatf("touches_box got %b expected %b", data[0], want));
        endtask

        function int pending();
            return touch_q.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [DW-1:0]                      s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [ebi_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata;
    logic                               cfg_valid;
    logic                               cfg_ready;
    ebi_pkg::cfg_index_t                cfg_index;
    logic [CW-1:0]                      cfg_data;

    touch_scoreboard board = new();
    bit no_idle = 1'b0;
    int cur_xl = COORD_MIN;
    int cur_yl = COORD_MIN;
    int cur_xh = COORD_MAX;
    int cur_yh = COORD_MAX;

    edge_box_intersection_core #(
        .COORD_WIDTH(CW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Coordinates cluster around the given bounds so that most segments
    // land near the box edges, with some drawn from the whole range.
    function automatic int pick_coord(int lo, int hi);
        int a;
        int b;
        int v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0, 1: v = rnd(COORD_MIN, COORD_MAX);
            2:    v = lo;
            3:    v = hi;
            4:    v = lo + rnd(-1, 1);
            5:    v = hi + rnd(-1, 1);
            default: v = rnd(a - 64, b + 64);
        endcase
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task send_segment(logic [DW-1:0] seg);
        while (!no_idle && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_segment(seg);
    endtask

    task send_xy(int sx, int sy, int fx, int fy);
        send_segment({fy[CW-1:0], fx[CW-1:0], sy[CW-1:0], sx[CW-1:0]});
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(ebi_pkg::cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_box_reg(idx, value[CW-1:0]);
    endtask

    // The box is only rewritten once every outstanding result has come back.
    task set_box(int xl, int yl, int xh, int yh);
        wait_drained();
        write_reg(ebi_pkg::REG_BOX_X_LOW, xl);
        write_reg(ebi_pkg::REG_BOX_Y_LOW, yl);
        write_reg(ebi_pkg::REG_BOX_X_HIGH, xh);
        write_reg(ebi_pkg::REG_BOX_Y_HIGH, yh);
        cfg_valid <= 1'b0;
        cur_xl = xl;
        cur_yl = yl;
        cur_xh = xh;
        cur_yh = yh;
    endtask

    task pick_box(int kind);
        int cx;
        int cy;
        int w;
        int h;
        int a;
        int b;
        cx = rnd(-30000, 30000);
        cy = rnd(-30000, 30000);
        w  = rnd(0, 2000);
        h  = rnd(0, 2000);
        case (kind)
            0: set_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
            1, 9: set_box(cx - w / 2, cy - h / 2, cx + w / 2, cy + h / 2);
            2: set_box(rnd(COORD_MIN, COORD_MAX), rnd(COORD_MIN, COORD_MAX),
                       rnd(COORD_MIN, COORD_MAX), rnd(COORD_MIN, COORD_MAX));
            3: set_box(cx + w / 2 + 1, cy + h / 2 + 1, cx - w / 2, cy - h / 2);
            4: set_box(cx, cy - h / 2, cx, cy + h / 2);
            5: set_box(cx, cy, cx, cy);
            6:
            begin
                a = rnd(0, 500);
                b = rnd(0, 500);
                set_box(COORD_MIN, COORD_MAX - a, COORD_MIN + b, COORD_MAX);
            end
            7: set_box(COORD_MIN + rnd(0, 100), COORD_MIN + rnd(0, 100),
                       COORD_MAX - rnd(0, 100), COORD_MAX - rnd(0, 100));
            default: set_box(cx - w / 2, cy, cx + w / 2, cy);
        endcase
    endtask

    task random_segment();
        int sx;
        int sy;
        int fx;
        int fy;
        sx = pick_coord(cur_xl, cur_xh);
        sy = pick_coord(cur_yl, cur_yh);
        fx = pick_coord(cur_xl, cur_xh);
        fy = pick_coord(cur_yl, cur_yh);
        case ($urandom_range(0, 9))
            0: send_segment({$urandom, $urandom});
            1: send_xy(sx, sy, sx, sy);
            2:
            begin
                sx = $urandom_range(0, 1) ? cur_xl : cur_xh;
                send_xy(sx, sy, sx, fy);
            end
            3:
            begin
                sy = $urandom_range(0, 1) ? cur_yl : cur_yh;
                send_xy(sx, sy, fx, sy);
            end
            default: send_xy(sx, sy, fx, fy);
        endcase
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 27);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= ebi_pkg::REG_BOX_X_LOW;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Box still at its reset value, the full coordinate range.
        send_xy(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_xy(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_xy(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_xy(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);

        set_box(-100, -50, 200, 150);
        send_xy(300, 0, 400, 10);
        send_xy(-300, 0, -200, 10);
        send_xy(0, 200, 10, 300);
        send_xy(0, -60, 10, -500);
        send_xy(0, 0, 1000, 1000);
        send_xy(1000, -1000, 150, 100);
        send_xy(10, 10, 10, 10);
        send_xy(500, 500, 500, 500);
        send_xy(-100, -50, -100, -50);
        send_xy(-1000, 0, 1000, 0);
        send_xy(150, 200, 250, 100);
        send_xy(160, 200, 260, 100);
        send_xy(-100, -500, -100, 500);
        send_xy(-500, -50, 500, -50);
        send_xy(-300, 40, 40, -300);

        // Low bounds above the high bounds.
        set_box(100, 100, -100, -100);
        send_xy(0, 0, 0, 0);
        send_xy(-200, 0, 200, 0);

        // A box of zero width.
        set_box(5, -10, 5, 10);
        send_xy(0, 0, 10, 0);
        send_xy(5, -100, 5, 100);

        // Each new box drains the pipeline before it is written.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_box(p);
            no_idle = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_segment();
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ebi_pkg.sv
src/ebi_side.sv
src/edge_box_intersection_core.sv
test/tb_edge_box_intersection_core.sv
